@@ src/hpsa_pkg.sv @@
// Shared types, widths and codes for the hash partition slot allocator.
package hpsa_pkg;

   localparam int MAX_PART_BITS_DEF = 10;
   localparam int SLOT_BITS_DEF     = 26;

   localparam int KEY_W     = 64;
   localparam int PAYLOAD_W = 64;
   localparam int PART_W    = 10;
   localparam int SLOT_W    = 25;
   localparam int PBITS_W   = 4;
   localparam int CAP_W     = 26;
   localparam int CSR_W     = 26;
   localparam int CSR_IDX_W = 2;

   localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(33554432);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_PART_BITS = 2'd0,
      CSR_CAPACITY  = 2'd1
   } csr_idx_type;

   typedef enum logic [1:0] {
      STAT_PLACED   = 2'd0,
      STAT_OVERFLOW = 2'd1,
      STAT_DROPPED  = 2'd2
   } status_type;

   typedef enum logic {
      FSM_CLEAR = 1'b0,
      FSM_RUN   = 1'b1
   } fsm_type;

   typedef struct packed {
      logic [KEY_W-1:0]     key;
      logic [PAYLOAD_W-1:0] payload;
   } req_type;

   typedef struct packed {
      logic [PART_W-1:0]    partition;
      logic [SLOT_W-1:0]    slot;
      logic [KEY_W-1:0]     out_key;
      logic [PAYLOAD_W-1:0] out_payload;
      logic [1:0]           status;
   } rsp_type;

endpackage

@@ src/hpsa_cnt_mem.sv @@
// Fill counter memory: one write port, one read port, registered read data.
module hpsa_cnt_mem #(
   parameter int ADDR_W = 10,
   parameter int DATA_W = 26
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem_ff [2**ADDR_W];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // read-first: a read of the entry being written returns the old value
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ src/hash_partition_slot_allocator.sv @@
// An accepted beat passes the lookup stage, then the output register with its response.
// Throughput: one beat per cycle while the output does not stall, set by the single
// read and single write port of the fill counter memory; a back-to-back hit on the
// same partition is forwarded. Reset: synchronous; afterwards a clearing pass zeroes
// all 2^MAX_PART_BITS counter entries (1024 by default), with req_ready held low.
module hash_partition_slot_allocator #(
   parameter int MAX_PART_BITS = hpsa_pkg::MAX_PART_BITS_DEF,
   parameter int SLOT_BITS     = hpsa_pkg::SLOT_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  hpsa_pkg::req_type                   req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output hpsa_pkg::rsp_type                   rsp_data,
   input  logic                                csr_we,
   input  logic [hpsa_pkg::CSR_IDX_W-1:0]      csr_addr,
   input  logic [hpsa_pkg::CSR_W-1:0]          csr_wdata
);

   import hpsa_pkg::*;

   localparam int CMP_W = ((SLOT_BITS > CAP_W) ? SLOT_BITS : CAP_W) + 1;
   localparam logic [CMP_W-1:0] CAP_LIMIT = CMP_W'(1) << (SLOT_BITS - 1);

   // configuration
   logic [PBITS_W-1:0] pbits_ff;
   logic [CAP_W-1:0]   cap_ff;

   // clearing sequencer
   fsm_type                  fsm_ff, fsm_in;
   logic [MAX_PART_BITS-1:0] clr_ff, clr_in;

   // lookup stage
   logic                     s1_valid_ff, s1_valid_in;
   req_type                  s1_req_ff;
   logic [MAX_PART_BITS-1:0] s1_part_ff;
   logic                     s1_fwd_ff;
   logic [SLOT_BITS-1:0]     fwd_data_ff;
   logic                     ovf_ff, ovf_in;

   // output register
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_ff;

   logic [MAX_PART_BITS-1:0] mask;
   logic [MAX_PART_BITS-1:0] req_part;
   logic                     req_fire;
   logic                     out_free;
   logic                     s1_go;
   logic [SLOT_BITS-1:0]     rd_data;
   logic [SLOT_BITS-1:0]     cur;
   logic [SLOT_BITS-1:0]     nxt;
   logic [CMP_W-1:0]         cap_ext;
   logic [CMP_W-1:0]         eff_cap;
   logic                     full;
   logic                     upd_en;
   logic                     mem_we;
   logic [MAX_PART_BITS-1:0] mem_waddr;
   logic [SLOT_BITS-1:0]     mem_wdata;
   rsp_type                  result;

   // partition mask saturates at MAX_PART_BITS by construction
   always_comb begin
      for (int i = 0; i < MAX_PART_BITS; i++) begin
         mask[i] = (32'(i) < 32'(pbits_ff));
      end
   end

   assign req_part = req_data.key[MAX_PART_BITS-1:0] & mask;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign s1_go     = s1_valid_ff && out_free;
   assign req_ready = (fsm_ff == FSM_RUN) && (!s1_valid_ff || out_free);
   assign req_fire  = req_valid && req_ready;

   // take the forwarded value when the read raced the write of the same entry
   assign cur     = s1_fwd_ff ? fwd_data_ff : rd_data;
   assign nxt     = cur + SLOT_BITS'(1);
   assign cap_ext = CMP_W'(cap_ff);
   assign eff_cap = (cap_ext > CAP_LIMIT) ? CAP_LIMIT : cap_ext;
   assign full    = (CMP_W'(cur) >= eff_cap);
   assign upd_en  = s1_go && !ovf_ff && !full;

   always_comb begin
      result.partition   = PART_W'(s1_part_ff);
      result.out_key     = s1_req_ff.key;
      result.out_payload = s1_req_ff.payload;
      result.slot        = '0;
      if (ovf_ff) begin
         result.status = STAT_DROPPED;
      end else if (full) begin
         result.status = STAT_OVERFLOW;
      end else begin
         result.status = STAT_PLACED;
         result.slot   = SLOT_W'(cur);
      end
   end

   always_comb begin
      mem_we    = upd_en;
      mem_waddr = s1_part_ff;
      mem_wdata = nxt;
      if (fsm_ff == FSM_CLEAR) begin
         mem_we    = 1'b1;
         mem_waddr = clr_ff;
         mem_wdata = '0;
      end
   end

   hpsa_cnt_mem #(
      .ADDR_W (MAX_PART_BITS),
      .DATA_W (SLOT_BITS)
   ) u_cnt_mem (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_en   (req_fire),
      .rd_addr (req_part),
      .rd_data (rd_data)
   );

   // clearing sequencer
   always_comb begin
      fsm_in = fsm_ff;
      clr_in = clr_ff;
      case (fsm_ff)
         FSM_CLEAR: begin
            clr_in = clr_ff + MAX_PART_BITS'(1);
            if (&clr_ff) begin
               fsm_in = FSM_RUN;
            end
         end
         FSM_RUN: begin
            clr_in = '0;
         end
         default: begin
            fsm_in = FSM_CLEAR;
            clr_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fsm_ff <= FSM_CLEAR;
         clr_ff <= '0;
      end else begin
         fsm_ff <= fsm_in;
         clr_ff <= clr_in;
      end
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         pbits_ff <= '0;
         cap_ff   <= CAP_RESET;
      end else if (csr_we) begin
         case (csr_idx_type'(csr_addr))
            CSR_PART_BITS: pbits_ff <= csr_wdata[PBITS_W-1:0];
            CSR_CAPACITY:  cap_ff   <= csr_wdata[CAP_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // control next values
   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_fire) begin
         s1_valid_in = 1'b1;
      end else if (s1_go) begin
         s1_valid_in = 1'b0;
      end

      rsp_valid_in = rsp_valid_ff;
      if (s1_go) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      ovf_in = ovf_ff || (s1_go && full);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         ovf_ff       <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         ovf_ff       <= ovf_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_req_ff  <= req_data;
         s1_part_ff <= req_part;
         s1_fwd_ff  <= upd_en && (s1_part_ff == req_part);
      end
      if (upd_en) begin
         fwd_data_ff <= nxt;
      end
      if (s1_go) begin
         rsp_ff <= result;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

@@ tb/tb_hash_partition_slot_allocator.sv @@
// Self-checking testbench for the hash partition slot allocator.
module tb_hash_partition_slot_allocator;
   timeunit 1ns;
   timeprecision 1ps;

   import hpsa_pkg::*;

   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_2 = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_3 = 2'd3;
   localparam int NUM_PARTS = 1 << MAX_PART_BITS_DEF;
   localparam logic [CAP_W-1:0] CAP_CEILING = CAP_W'(1 << (SLOT_BITS_DEF - 1));

   logic clock = 1'b0;
   logic reset;
   logic req_valid;
   logic req_ready;
   req_type req_data;
   logic rsp_valid;
   logic rsp_ready;
   rsp_type rsp_data;
   logic csr_we;
   logic [CSR_IDX_W-1:0] csr_addr;
   logic [CSR_W-1:0] csr_wdata;

   // mirror of the block's registers and counters
   logic [PBITS_W-1:0] mirror_part_bits;
   logic [CAP_W-1:0] mirror_capacity;
   logic [CAP_W-1:0] fill_count [NUM_PARTS];
   logic overflow_latched;

   rsp_type pending_placements [$];
   int mismatch_count;
   int send_idle_pct;
   int recv_idle_pct;
   int hold_off_len;

   hash_partition_slot_allocator dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata)
   );

   always #5 clock = ~clock;

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   // Work out the response for an accepted tuple and advance the counters.
   function automatic rsp_type place_tuple(input req_type beat);
      rsp_type placed;
      int unsigned nbits;
      logic [PART_W-1:0] part;
      logic [CAP_W-1:0] limit;
      nbits = (mirror_part_bits > MAX_PART_BITS_DEF) ? MAX_PART_BITS_DEF : mirror_part_bits;
      part = beat.key[PART_W-1:0] & PART_W'((1 << nbits) - 1);
      limit = (mirror_capacity > CAP_CEILING) ? CAP_CEILING : mirror_capacity;
      placed.partition = part;
      placed.slot = '0;
      placed.out_key = beat.key;
      placed.out_payload = beat.payload;
      if (overflow_latched) begin
         placed.status = STAT_DROPPED;
      end else if (fill_count[part] >= limit) begin
         overflow_latched = 1'b1;
         placed.status = STAT_OVERFLOW;
      end else begin
         placed.slot = fill_count[part][SLOT_W-1:0];
         fill_count[part] = fill_count[part] + 1'b1;
         placed.status = STAT_PLACED;
      end
      return placed;
   endfunction

   function automatic void check_field(input string name, input logic [63:0] want,
                                       input logic [63:0] got);
      if (got !== want) begin
         mismatch_count++;
         $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
      end
   endfunction

   // Enters at any time, returns at the edge that took the beat with valid still high.
   task automatic send_tuple(input logic [KEY_W-1:0] key, input logic [PAYLOAD_W-1:0] payload);
      req_type beat;
      beat.key = key;
      beat.payload = payload;
      @(negedge clock);
      csr_we <= 1'b0;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_data <= beat;
      req_valid <= 1'b1;
      do @(posedge clock); while (!req_ready);
      pending_placements.push_back(place_tuple(beat));
   endtask

   // Drop valid and wait for every outstanding response plus the pipeline depth.
   task automatic settle();
      @(negedge clock);
      req_valid <= 1'b0;
      csr_we <= 1'b0;
      while (pending_placements.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_W-1:0] value);
      @(negedge clock);
      req_valid <= 1'b0;
      csr_we <= 1'b1;
      csr_addr <= idx;
      csr_wdata <= value;
      @(posedge clock);
      if (idx == CSR_PART_BITS)
         mirror_part_bits = value[PBITS_W-1:0];
      else if (idx == CSR_CAPACITY)
         mirror_capacity = value[CAP_W-1:0];
   endtask

   task automatic test_tuple_extremes();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      // single partition, back-to-back beats hit the same counter
      send_tuple('0, '0);
      send_tuple('1, '1);
      send_tuple({32{2'b01}}, {32{2'b10}});
      send_tuple({32{2'b10}}, {32{2'b01}});
      send_tuple(64'h8000_0000_0000_0000, 64'h1);
      send_tuple(64'h1, 64'h8000_0000_0000_0000);
      settle();
   endtask

   task automatic test_partition_select();
      write_reg(CSR_PART_BITS, CSR_W'(MAX_PART_BITS_DEF));
      send_tuple(64'h3FF, rand64());
      send_tuple(64'h400, rand64());
      send_tuple(64'h2AA, rand64());
      send_tuple(64'h155, rand64());
      send_tuple('1, rand64());
      settle();
      // above the maximum, saturate to the maximum
      write_reg(CSR_PART_BITS, CSR_W'(15));
      send_tuple('1, rand64());
      send_tuple(64'hFFFF_FC00, rand64());
      settle();
      write_reg(CSR_PART_BITS, CSR_W'(1));
      // writes to unused indexes must leave both registers alone
      write_reg(CSR_SPARE_2, '1);
      write_reg(CSR_SPARE_3, '1);
      send_tuple(64'h2, rand64());
      send_tuple('1, rand64());
      settle();
   endtask

   task automatic test_capacity_saturation();
      write_reg(CSR_CAPACITY, '1);
      send_tuple(rand64(), rand64());
      send_tuple(rand64(), rand64());
      settle();
      write_reg(CSR_CAPACITY, CAP_RESET);
   endtask

   task automatic apply_random_setting();
      logic [CSR_W-1:0] cap;
      case ($urandom_range(2))
         0: cap = CAP_RESET;
         1: cap = '1;
         default: cap = CSR_W'($urandom_range(33554431, 4096));
      endcase
      settle();
      write_reg(CSR_PART_BITS, CSR_W'($urandom_range(15)));
      write_reg(CSR_CAPACITY, cap);
   endtask

   task automatic test_random_traffic();
      logic [KEY_W-1:0] key;
      for (int phase = 0; phase < 3; phase++) begin
         send_idle_pct = (phase == 0) ? 35 : (phase == 1) ? 59 : 0;
         recv_idle_pct = (phase == 0) ? 59 : (phase == 1) ? 35 : 0;
         repeat (3) begin
            apply_random_setting();
            repeat (170) begin
               key = rand64();
               // crowd a few partitions so counters climb and beats collide
               if ($urandom_range(1))
                  key[PART_W-1:0] = PART_W'($urandom_range(7));
               send_tuple(key, rand64());
            end
         end
      end
      settle();
   endtask

   task automatic test_receiver_hold_off();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      @(posedge clock);
      hold_off_len = 300;
      repeat (60) send_tuple(rand64(), rand64());
      settle();
   endtask

   // Run last: the overflow flag stays set until reset.
   task automatic test_overflow_then_drop();
      logic [KEY_W-1:0] key;
      send_idle_pct = 0;
      recv_idle_pct = 0;
      write_reg(CSR_PART_BITS, CSR_W'(3));
      // leave two free slots in partition five; the third beat overflows
      write_reg(CSR_CAPACITY, fill_count[5] + CSR_W'(2));
      repeat (3) begin
         key = rand64();
         key[2:0] = 3'd5;
         send_tuple(key, rand64());
      end
      settle();
      write_reg(CSR_CAPACITY, '0);
      write_reg(CSR_PART_BITS, '0);
      send_idle_pct = 35;
      recv_idle_pct = 59;
      repeat (50) send_tuple(rand64(), rand64());
      settle();
      write_reg(CSR_PART_BITS, CSR_W'(MAX_PART_BITS_DEF));
      repeat (50) send_tuple(rand64(), rand64());
      settle();
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      csr_we = 1'b0;
      csr_addr = '0;
      csr_wdata = '0;
      send_idle_pct = 0;
      recv_idle_pct = 0;
      hold_off_len = 0;
      mismatch_count = 0;
      mirror_part_bits = '0;
      mirror_capacity = CAP_RESET;
      overflow_latched = 1'b0;
      foreach (fill_count[i]) fill_count[i] = '0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_tuple_extremes();
      test_partition_select();
      test_capacity_saturation();
      test_random_traffic();
      test_receiver_hold_off();
      test_overflow_then_drop();

      if (mismatch_count == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

   // Receiver: random stalls, plus a long hold-off on request.
   initial begin : rsp_side
      int stall_left;
      stall_left = 0;
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_off_len > 0) begin
            stall_left = hold_off_len;
            hold_off_len = 0;
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   always @(posedge clock) begin : rsp_check
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_placements.size() == 0) begin
            mismatch_count++;
            $display("%0t: unexpected response beat, expected none, got %p", $time, rsp_data);
         end else begin
            want = pending_placements.pop_front();
            check_field("partition", 64'(want.partition), 64'(rsp_data.partition));
            check_field("slot", 64'(want.slot), 64'(rsp_data.slot));
            check_field("out_key", want.out_key, rsp_data.out_key);
            check_field("out_payload", want.out_payload, rsp_data.out_payload);
            check_field("status", 64'(want.status), 64'(rsp_data.status));
         end
      end
   end

   initial begin
      #2_000_000;
      $display("Verification failed");
      $finish;
   end

endmodule
